>>> hdl/ecpr_pkg.sv
`timescale 1ns / 1ps

package ecpr_pkg;

   localparam int FRAMES_DEF  = 4;
   localparam int PAGE_BITS   = 20;
   localparam int FRAME_OUT_W = 2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOK,
      ST_LOOK_END,
      ST_SCAN,
      ST_FALLBACK,
      ST_FILL,
      ST_HIT
   } state_type;

   typedef enum logic [1:0] {
      RD_IDX,
      RD_SCAN,
      RD_VICTIM,
      RD_HAND
   } rd_sel_type;

   typedef struct packed {
      logic       capture;
      logic       look_step;
      logic       hit_take;
      logic       scan_init;
      logic       scan_step;
      logic       fallback;
      logic       fill_commit;
      logic       hit_commit;
      rd_sel_type rd_sel;
   } dp_cmd_type;

   typedef struct packed {
      logic hit_now;
      logic look_last;
      logic scan_match;
      logic scan_last;
      logic out_busy;
   } dp_status_type;

endpackage

>>> hdl/ecpr_ifs.sv
`timescale 1ns / 1ps

interface ecpr_req_if;
   import ecpr_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [PAGE_BITS-1:0] page_number;
   logic                 is_write;
   modport source (output valid, page_number, is_write, input ready);
   modport sink (input valid, page_number, is_write, output ready);
endinterface

interface ecpr_rsp_if;
   import ecpr_pkg::*;
   logic                   valid;
   logic                   ready;
   logic                   hit;
   logic [FRAME_OUT_W-1:0] frame_index;
   logic                   evicted_valid;
   logic [PAGE_BITS-1:0]   evicted_page;
   logic                   evicted_dirty;
   logic [FRAME_OUT_W-1:0] hand_position;
   modport source (output valid, hit, frame_index, evicted_valid, evicted_page,
                   evicted_dirty, hand_position, input ready);
   modport sink (input valid, hit, frame_index, evicted_valid, evicted_page,
                 evicted_dirty, hand_position, output ready);
endinterface

>>> hdl/ecpr_ctrl.sv
`timescale 1ns / 1ps

module ecpr_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  ecpr_pkg::dp_status_type status,
   output ecpr_pkg::dp_cmd_type    cmd
);
   import ecpr_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.rd_sel = RD_IDX;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_LOOK;
            end
         end
         ST_LOOK: begin
            cmd.rd_sel = RD_IDX;
            if (status.hit_now) begin
               cmd.hit_take = 1'b1;
               state_in     = ST_HIT;
            end else begin
               cmd.look_step = 1'b1;
               if (status.look_last) begin
                  state_in = ST_LOOK_END;
               end
            end
         end
         ST_LOOK_END: begin
            if (status.hit_now) begin
               cmd.hit_take = 1'b1;
               state_in     = ST_HIT;
            end else begin
               cmd.scan_init = 1'b1;
               state_in      = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.rd_sel    = RD_SCAN;
            cmd.scan_step = 1'b1;
            if (status.scan_match) begin
               state_in = ST_FILL;
            end else if (status.scan_last) begin
               state_in = ST_FALLBACK;
            end
         end
         ST_FALLBACK: begin
            cmd.rd_sel   = RD_HAND;
            cmd.fallback = 1'b1;
            state_in     = ST_FILL;
         end
         ST_FILL: begin
            cmd.rd_sel = RD_VICTIM;
            if (!status.out_busy) begin
               cmd.fill_commit = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         ST_HIT: begin
            if (!status.out_busy) begin
               cmd.hit_commit = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

>>> hdl/ecpr_datapath.sv
`timescale 1ns / 1ps

module ecpr_datapath #(
   parameter int FRAMES = ecpr_pkg::FRAMES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  ecpr_pkg::dp_cmd_type                cmd,
   output ecpr_pkg::dp_status_type             status,
   input  logic [ecpr_pkg::PAGE_BITS-1:0]      page_number,
   input  logic                                is_write,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic                                rsp_hit,
   output logic [ecpr_pkg::FRAME_OUT_W-1:0]    rsp_frame_index,
   output logic                                rsp_evicted_valid,
   output logic [ecpr_pkg::PAGE_BITS-1:0]      rsp_evicted_page,
   output logic                                rsp_evicted_dirty,
   output logic [ecpr_pkg::FRAME_OUT_W-1:0]    rsp_hand_position
);
   import ecpr_pkg::*;

   localparam int IDX_W = $clog2(FRAMES);
   localparam logic [IDX_W-1:0] LAST = IDX_W'(FRAMES - 1);

   logic [PAGE_BITS-1:0] tag_mem [FRAMES];
   logic [PAGE_BITS-1:0] tag_q_ff;
   logic [PAGE_BITS-1:0] page_ff;
   logic                 wr_ff;

   logic [FRAMES-1:0] valid_ff, valid_in;
   logic [FRAMES-1:0] use_ff, use_in;
   logic [FRAMES-1:0] mod_ff, mod_in;
   logic [IDX_W-1:0]  hand_ff, hand_in;

   logic [IDX_W-1:0] idx_ff, cmp_idx_ff, scan_f_ff, scan_k_ff, victim_ff;
   logic [1:0]       pass_ff;
   logic             cmp_go_ff;
   logic [IDX_W-1:0] rd_addr;
   logic [IDX_W-1:0] victim_next;

   logic                   rsp_valid_ff;
   logic                   rsp_hit_ff;
   logic [FRAME_OUT_W-1:0] rsp_frame_ff;
   logic                   rsp_ev_valid_ff;
   logic [PAGE_BITS-1:0]   rsp_ev_page_ff;
   logic                   rsp_ev_dirty_ff;
   logic [FRAME_OUT_W-1:0] rsp_hand_ff;

   function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] f);
      logic [IDX_W-1:0] r;
      r = (f == LAST) ? '0 : f + 1'b1;
      return r;
   endfunction

   always_comb begin
      case (cmd.rd_sel)
         RD_IDX:    rd_addr = idx_ff;
         RD_SCAN:   rd_addr = scan_f_ff;
         RD_VICTIM: rd_addr = victim_ff;
         RD_HAND:   rd_addr = hand_ff;
         default:   rd_addr = idx_ff;
      endcase
   end

   assign victim_next = wrap_inc(victim_ff);

   assign status.hit_now    = cmp_go_ff && valid_ff[cmp_idx_ff] && (tag_q_ff == page_ff);
   assign status.look_last  = (idx_ff == LAST);
   assign status.scan_match = !use_ff[scan_f_ff] && (mod_ff[scan_f_ff] == pass_ff[0]);
   assign status.scan_last  = (scan_k_ff == LAST) && (pass_ff == 2'd3);
   assign status.out_busy   = rsp_valid_ff && !rsp_ready;

   // tag store, registered read
   always_ff @(posedge clock) begin
      if (cmd.fill_commit) begin
         tag_mem[victim_ff] <= page_ff;
      end
      tag_q_ff <= tag_mem[rd_addr];
   end

   always_comb begin
      valid_in = valid_ff;
      use_in   = use_ff;
      mod_in   = mod_ff;
      hand_in  = hand_ff;
      // second-chance pass clears use bits it walks over
      if (cmd.scan_step && !status.scan_match && pass_ff[0]) begin
         use_in[scan_f_ff] = 1'b0;
      end
      if (cmd.hit_commit) begin
         use_in[victim_ff] = 1'b1;
         if (wr_ff) begin
            mod_in[victim_ff] = 1'b1;
         end
      end
      if (cmd.fill_commit) begin
         valid_in[victim_ff] = 1'b1;
         use_in[victim_ff]   = 1'b1;
         mod_in[victim_ff]   = wr_ff;
         hand_in             = victim_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         use_ff    <= '0;
         mod_ff    <= '0;
         hand_ff   <= '0;
         cmp_go_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         use_ff    <= use_in;
         mod_ff    <= mod_in;
         hand_ff   <= hand_in;
         cmp_go_ff <= cmd.look_step;
      end
   end

   always_ff @(posedge clock) begin
      cmp_idx_ff <= idx_ff;
      if (cmd.capture) begin
         page_ff <= page_number;
         wr_ff   <= is_write;
         idx_ff  <= '0;
      end else if (cmd.look_step) begin
         idx_ff <= idx_ff + 1'b1;
      end
      if (cmd.hit_take) begin
         victim_ff <= cmp_idx_ff;
      end else if (cmd.fallback) begin
         victim_ff <= hand_ff;
      end else if (cmd.scan_step && status.scan_match) begin
         victim_ff <= scan_f_ff;
      end
      if (cmd.scan_init) begin
         scan_f_ff <= hand_ff;
         scan_k_ff <= '0;
         pass_ff   <= '0;
      end else if (cmd.scan_step && !status.scan_match) begin
         if (scan_k_ff == LAST) begin
            scan_k_ff <= '0;
            scan_f_ff <= hand_ff;
            pass_ff   <= pass_ff + 1'b1;
         end else begin
            scan_k_ff <= scan_k_ff + 1'b1;
            scan_f_ff <= wrap_inc(scan_f_ff);
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.hit_commit || cmd.fill_commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.hit_commit) begin
         rsp_hit_ff      <= 1'b1;
         rsp_frame_ff    <= FRAME_OUT_W'(victim_ff);
         rsp_ev_valid_ff <= 1'b0;
         rsp_ev_page_ff  <= '0;
         rsp_ev_dirty_ff <= 1'b0;
         rsp_hand_ff     <= FRAME_OUT_W'(hand_ff);
      end else if (cmd.fill_commit) begin
         rsp_hit_ff      <= 1'b0;
         rsp_frame_ff    <= FRAME_OUT_W'(victim_ff);
         rsp_ev_valid_ff <= valid_ff[victim_ff];
         rsp_ev_page_ff  <= valid_ff[victim_ff] ? tag_q_ff : '0;
         rsp_ev_dirty_ff <= valid_ff[victim_ff] && mod_ff[victim_ff];
         rsp_hand_ff     <= FRAME_OUT_W'(victim_next);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = rsp_hit_ff;
   assign rsp_frame_index   = rsp_frame_ff;
   assign rsp_evicted_valid = rsp_ev_valid_ff;
   assign rsp_evicted_page  = rsp_ev_page_ff;
   assign rsp_evicted_dirty = rsp_ev_dirty_ff;
   assign rsp_hand_position = rsp_hand_ff;

endmodule

>>> hdl/enhanced_clock_page_replacement_unit.sv
`timescale 1ns / 1ps
// Channel   Dir   Payload
// req_if    in    page_number, is_write
// rsp_if    out   hit, frame_index, evicted_valid, evicted_page, evicted_dirty,
//                 hand_position
//
// One item at a time; lookup reads one frame per cycle from the tag store.
// Hit: the result follows a lookup that finds the page. Miss: lookup, then
// scan from the hand (else the hand frame itself) and one fill step.
// The next item is taken the cycle after the result is loaded.
// Synchronous reset clears frame valid, use and modify bits and the hand.
// A new item is taken while a result waits; commit stalls until it is taken.

module enhanced_clock_page_replacement_unit #(
   parameter int FRAMES = ecpr_pkg::FRAMES_DEF
) (
   input logic        clock,
   input logic        reset,
   ecpr_req_if.sink   req_if,
   ecpr_rsp_if.source rsp_if
);
   import ecpr_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   ecpr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   ecpr_datapath #(
      .FRAMES (FRAMES)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .page_number       (req_if.page_number),
      .is_write          (req_if.is_write),
      .rsp_ready         (rsp_if.ready),
      .rsp_valid         (rsp_if.valid),
      .rsp_hit           (rsp_if.hit),
      .rsp_frame_index   (rsp_if.frame_index),
      .rsp_evicted_valid (rsp_if.evicted_valid),
      .rsp_evicted_page  (rsp_if.evicted_page),
      .rsp_evicted_dirty (rsp_if.evicted_dirty),
      .rsp_hand_position (rsp_if.hand_position)
   );

endmodule
